FILE: design/cau_pkg.sv
// Package for the complex arithmetic unit: word sizes, opcodes, status codes
// and the item record that travels from the front end through the queue.
// No dependencies.
package cau_pkg;

  localparam int WORD_BITS   = 32;
  localparam int FRAC_BITS   = 16;
  localparam int DBL_BITS    = 2 * WORD_BITS;
  localparam int SUM_BITS    = DBL_BITS + 1;
  localparam int NUM_BITS    = SUM_BITS + FRAC_BITS;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  typedef logic signed [WORD_BITS-1:0] word_t;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_CONJ = 3'd4,
    OP_NEG  = 3'd5,
    OP_ABS2 = 3'd6,
    OP_ABS  = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_SAT      = 2'd2
  } status_e;

  // How the back end treats an item in its shared iteration stages.
  typedef enum logic [1:0] {
    MODE_PASS = 2'd0,
    MODE_DIV  = 2'd1,
    MODE_SQRT = 2'd2
  } mode_e;

  typedef struct packed {
    op_e   op;
    mode_e mode;
    logic  dz;
    word_t a_re;
    word_t a_im;
    word_t b_re;
    word_t b_im;
  } item_t;

  typedef struct packed {
    logic  vld;
    item_t item;
  } item_chan_t;

endpackage

FILE: design/cau_if.sv
// Valid/ready channel interfaces for the complex arithmetic unit.
// Depends on cau_pkg.
interface cau_in_if import cau_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [2:0]        opcode;
  word_t             a_re;
  word_t             a_im;
  word_t             b_re;
  word_t             b_im;

  modport source (output valid, opcode, a_re, a_im, b_re, b_im, input ready);
  modport sink   (input valid, opcode, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_out_if import cau_pkg::*; ();
  logic              valid;
  logic              ready;
  word_t             res_re;
  word_t             res_im;
  logic [1:0]        status;

  modport source (output valid, res_re, res_im, status, input ready);
  modport sink   (input valid, res_re, res_im, status, output ready);
endinterface

FILE: design/complex_arithmetic_unit.sv
// Complex arithmetic unit top level. Results pass through a chain of one-bit
// divide/square-root stages. Throughput is one item per cycle while the
// output is not stalled. Reset (asynchronous, active low) empties the queue
// and clears every pipeline valid bit; no data is held across reset.
// Depends on cau_pkg, cau_if, cau_front, cau_queue and cau_back.
module complex_arithmetic_unit import cau_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  cau_in_if.sink    in_ch,
  cau_out_if.source out_ch
);

  // The front end decodes each transfer and writes it into the queue.
  // The queue lets new items arrive while the back end is held by a
  // result that has not been taken yet.
  item_chan_t enq, deq;
  logic       enq_ready;
  logic       pop;

  cau_front u_front (
    .in_ch       (in_ch),
    .enq_ready_i (enq_ready),
    .enq_o       (enq)
  );

  cau_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .enq_i       (enq),
    .enq_ready_o (enq_ready),
    .deq_o       (deq),
    .pop_i       (pop)
  );

  // The back end is one pipeline that moves as a whole whenever its
  // output register is empty or being taken. Every opcode passes through
  // the same number of stages, so results leave in arrival order.
  cau_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .deq_i  (deq),
    .pop_o  (pop),
    .out_ch (out_ch)
  );

  // A held result must freeze the back end, so nothing leaves the queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && !out_ch.ready) |-> !pop)
    else $error("queue popped while the output was stalled");

  // The back end never pops an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> deq.vld)
    else $error("pop from an empty queue");

  // A divide-by-zero result carries zero in both parts.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && (out_ch.status == ST_DIV_ZERO)) |->
      ((out_ch.res_re == '0) && (out_ch.res_im == '0)))
    else $error("divide-by-zero result is not zero");

endmodule

FILE: design/cau_front.sv
// Front end: takes input transfers, decodes the opcode and flags a zero
// divisor, then hands the item to the queue. Depends on cau_pkg and cau_if.
module cau_front import cau_pkg::*; (
  cau_in_if.sink     in_ch,
  input  logic       enq_ready_i,
  output item_chan_t enq_o
);

  op_e op;

  assign op = op_e'(in_ch.opcode);
  assign in_ch.ready = enq_ready_i;

  always_comb begin
    enq_o.vld       = in_ch.valid;
    enq_o.item.op   = op;
    enq_o.item.a_re = in_ch.a_re;
    enq_o.item.a_im = in_ch.a_im;
    enq_o.item.b_re = in_ch.b_re;
    enq_o.item.b_im = in_ch.b_im;
    enq_o.item.dz   = (op == OP_DIV) && (in_ch.b_re == '0) && (in_ch.b_im == '0);
    unique case (op)
      OP_DIV:  enq_o.item.mode = MODE_DIV;
      OP_ABS:  enq_o.item.mode = MODE_SQRT;
      default: enq_o.item.mode = MODE_PASS;
    endcase
  end

endmodule

FILE: design/cau_queue.sv
// Short first-in first-out queue between the front and back ends.
// Depends on cau_pkg.
module cau_queue import cau_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  item_chan_t enq_i,
  output logic       enq_ready_o,
  output item_chan_t deq_o,
  input  logic       pop_i
);

  item_t                entry_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_BITS:0]   cnt_q, cnt_d;
  logic                 push;

  assign enq_ready_o = (cnt_q != (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign push        = enq_i.vld && enq_ready_o;
  assign deq_o.vld   = (cnt_q != '0);
  assign deq_o.item  = entry_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= enq_i.item;
    end
  end

endmodule

FILE: design/cau_back.sv
// Back end: multiply stage, sum stage, prepare stage, a chain of shared
// divide/square-root iteration stages and a saturating output register.
// Depends on cau_pkg and cau_if.
module cau_back import cau_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  item_chan_t deq_i,
  output logic       pop_o,
  cau_out_if.source  out_ch
);

  localparam int HI_BITS = NUM_BITS - WORD_BITS;

  typedef struct packed {
    op_e                      op;
    mode_e                    mode;
    logic                     dz;
    word_t                    a_re;
    word_t                    a_im;
    word_t                    b_re;
    word_t                    b_im;
    logic [5:0][DBL_BITS-1:0] p;
  } s1_t;

  typedef struct packed {
    op_e                 op;
    mode_e               mode;
    logic                dz;
    logic [SUM_BITS-1:0] s_re;
    logic [SUM_BITS-1:0] s_im;
    logic [DBL_BITS-1:0] den;
  } s2_t;

  typedef struct packed {
    logic [SUM_BITS-1:0]  rem;
    logic [DBL_BITS-1:0]  src;
    logic [WORD_BITS-1:0] q;
    logic                 neg;
    logic                 big;
  } lane_t;

  typedef struct packed {
    mode_e               mode;
    logic                dz;
    logic [DBL_BITS-1:0] den;
    lane_t [1:0]         ln;
  } it_t;

  function automatic logic [SUM_BITS-1:0] sx_w(word_t x);
    return {{(SUM_BITS-WORD_BITS){x[WORD_BITS-1]}}, x};
  endfunction

  function automatic logic [SUM_BITS-1:0] sx_d(logic [DBL_BITS-1:0] x);
    return {x[DBL_BITS-1], x};
  endfunction

  // One restoring step: one quotient bit for division, one root bit for
  // the square root (two radicand bits brought in).
  function automatic lane_t lane_step(lane_t l, logic en, logic sq,
                                      logic [DBL_BITS-1:0] den);
    logic [SUM_BITS-1:0] r2;
    logic [SUM_BITS-1:0] tr;
    lane_t               o;
    o = l;
    if (sq) begin
      r2    = {l.rem[SUM_BITS-3:0], l.src[DBL_BITS-1 -: 2]};
      o.src = l.src << 2;
      tr    = {{(SUM_BITS-WORD_BITS-2){1'b0}}, l.q, 2'b01};
    end else begin
      r2    = {l.rem[SUM_BITS-2:0], l.src[DBL_BITS-1]};
      o.src = l.src << 1;
      tr    = {1'b0, den};
    end
    if (r2 >= tr) begin
      o.rem = r2 - tr;
      o.q   = {l.q[WORD_BITS-2:0], 1'b1};
    end else begin
      o.rem = r2;
      o.q   = {l.q[WORD_BITS-2:0], 1'b0};
    end
    if (!en) begin
      o = l;
    end
    return o;
  endfunction

  // Clamp a sign and magnitude part to the word range; the top bit flags
  // saturation.
  function automatic logic [WORD_BITS:0] sat_part(lane_t l);
    logic [WORD_BITS-1:0] lim;
    logic [WORD_BITS:0]   r;
    lim = {1'b1, {(WORD_BITS-1){1'b0}}};
    if (l.big) begin
      r = {1'b1, (l.neg ? lim : ~lim)};
    end else if (!l.neg) begin
      r = l.q[WORD_BITS-1] ? {1'b1, ~lim} : {1'b0, l.q};
    end else begin
      r = (l.q > lim) ? {1'b1, lim} : {1'b0, ~l.q + 1'b1};
    end
    return r;
  endfunction

  logic                 adv;
  logic                 s1_vld_q, s2_vld_q, out_vld_q;
  logic [WORD_BITS:0]   it_vld_q;
  s1_t                  s1_d, s1_q;
  s2_t                  s2_d, s2_q;
  it_t                  prep_d;
  it_t                  it_q [WORD_BITS+1];
  word_t                res_re_d, res_im_d, res_re_q, res_im_q;
  logic [1:0]           status_d, status_q;
  logic [WORD_BITS:0]   sat_re, sat_im;
  logic signed [DBL_BITS-1:0] pr [6];
  word_t                m4, m5;

  assign adv   = !out_vld_q || out_ch.ready;
  assign pop_o = adv && deq_i.vld;

  // Multiply stage.
  always_comb begin
    m4    = (deq_i.item.op == OP_DIV) ? deq_i.item.b_re : deq_i.item.a_re;
    m5    = (deq_i.item.op == OP_DIV) ? deq_i.item.b_im : deq_i.item.a_im;
    pr[0] = deq_i.item.a_re * deq_i.item.b_re;
    pr[1] = deq_i.item.a_im * deq_i.item.b_im;
    pr[2] = deq_i.item.a_re * deq_i.item.b_im;
    pr[3] = deq_i.item.a_im * deq_i.item.b_re;
    pr[4] = m4 * m4;
    pr[5] = m5 * m5;
    s1_d.op   = deq_i.item.op;
    s1_d.mode = deq_i.item.mode;
    s1_d.dz   = deq_i.item.dz;
    s1_d.a_re = deq_i.item.a_re;
    s1_d.a_im = deq_i.item.a_im;
    s1_d.b_re = deq_i.item.b_re;
    s1_d.b_im = deq_i.item.b_im;
    for (int i = 0; i < 6; i++) begin
      s1_d.p[i] = pr[i];
    end
  end

  // Sum stage.
  always_comb begin
    logic [SUM_BITS-1:0] den_sum;
    den_sum   = sx_d(s1_q.p[4]) + sx_d(s1_q.p[5]);
    s2_d.op   = s1_q.op;
    s2_d.mode = s1_q.mode;
    s2_d.dz   = s1_q.dz;
    s2_d.den  = den_sum[DBL_BITS-1:0];
    unique case (s1_q.op) inside
      OP_ADD: begin
        s2_d.s_re = sx_w(s1_q.a_re) + sx_w(s1_q.b_re);
        s2_d.s_im = sx_w(s1_q.a_im) + sx_w(s1_q.b_im);
      end
      OP_SUB: begin
        s2_d.s_re = sx_w(s1_q.a_re) - sx_w(s1_q.b_re);
        s2_d.s_im = sx_w(s1_q.a_im) - sx_w(s1_q.b_im);
      end
      OP_CONJ: begin
        s2_d.s_re = sx_w(s1_q.a_re);
        s2_d.s_im = '0 - sx_w(s1_q.a_im);
      end
      OP_NEG: begin
        s2_d.s_re = '0 - sx_w(s1_q.a_re);
        s2_d.s_im = '0 - sx_w(s1_q.a_im);
      end
      OP_MUL: begin
        s2_d.s_re = sx_d(s1_q.p[0]) - sx_d(s1_q.p[1]);
        s2_d.s_im = sx_d(s1_q.p[2]) + sx_d(s1_q.p[3]);
      end
      OP_DIV: begin
        s2_d.s_re = sx_d(s1_q.p[0]) + sx_d(s1_q.p[1]);
        s2_d.s_im = sx_d(s1_q.p[3]) - sx_d(s1_q.p[2]);
      end
      OP_ABS2, OP_ABS: begin
        s2_d.s_re = den_sum;
        s2_d.s_im = '0;
      end
      default: begin
        s2_d.s_re = '0;
        s2_d.s_im = '0;
      end
    endcase
  end

  // Prepare stage: sign and magnitude, scaling, and the divider or root
  // start values with the quotient overflow check.
  always_comb begin
    logic [SUM_BITS-1:0] s, absv, shv;
    logic [NUM_BITS-1:0] num;
    logic [HI_BITS-1:0]  hi;
    prep_d.mode = s2_q.mode;
    prep_d.dz   = s2_q.dz;
    prep_d.den  = s2_q.den;
    for (int i = 0; i < 2; i++) begin
      s    = (i == 0) ? s2_q.s_re : s2_q.s_im;
      absv = s[SUM_BITS-1] ? ('0 - s) : s;
      shv  = ((s2_q.op == OP_MUL) || (s2_q.op == OP_ABS2)) ? (absv >> FRAC_BITS) : absv;
      num  = {absv, {FRAC_BITS{1'b0}}};
      hi   = num[NUM_BITS-1:WORD_BITS];
      prep_d.ln[i].rem = '0;
      prep_d.ln[i].src = '0;
      prep_d.ln[i].q   = shv[WORD_BITS-1:0];
      prep_d.ln[i].big = |shv[SUM_BITS-1:WORD_BITS];
      prep_d.ln[i].neg = s[SUM_BITS-1];
      if (s2_q.mode == MODE_DIV) begin
        prep_d.ln[i].rem = SUM_BITS'(hi);
        prep_d.ln[i].src = {num[WORD_BITS-1:0], {WORD_BITS{1'b0}}};
        prep_d.ln[i].q   = '0;
        prep_d.ln[i].big = NUM_BITS'(hi) >= NUM_BITS'(s2_q.den);
      end else if ((s2_q.mode == MODE_SQRT) && (i == 0)) begin
        prep_d.ln[i].src = absv[DBL_BITS-1:0];
        prep_d.ln[i].q   = '0;
        prep_d.ln[i].big = 1'b0;
        prep_d.ln[i].neg = 1'b0;
      end
    end
  end

  // Output formatting.
  always_comb begin
    sat_re = sat_part(it_q[WORD_BITS].ln[0]);
    sat_im = sat_part(it_q[WORD_BITS].ln[1]);
    if (it_q[WORD_BITS].dz) begin
      res_re_d = '0;
      res_im_d = '0;
      status_d = ST_DIV_ZERO;
    end else begin
      res_re_d = sat_re[WORD_BITS-1:0];
      res_im_d = sat_im[WORD_BITS-1:0];
      status_d = (sat_re[WORD_BITS] || sat_im[WORD_BITS]) ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      it_vld_q  <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q  <= deq_i.vld;
      s2_vld_q  <= s1_vld_q;
      it_vld_q  <= {it_vld_q[WORD_BITS-1:0], s2_vld_q};
      out_vld_q <= it_vld_q[WORD_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q     <= s1_d;
      s2_q     <= s2_d;
      it_q[0]  <= prep_d;
      res_re_q <= res_re_d;
      res_im_q <= res_im_d;
      status_q <= status_d;
    end
  end

  for (genvar k = 0; k < WORD_BITS; k++) begin : g_iter
    always_ff @(posedge clk_i) begin
      if (adv) begin
        it_q[k+1].mode  <= it_q[k].mode;
        it_q[k+1].dz    <= it_q[k].dz;
        it_q[k+1].den   <= it_q[k].den;
        it_q[k+1].ln[0] <= lane_step(it_q[k].ln[0], it_q[k].mode != MODE_PASS,
                                     it_q[k].mode == MODE_SQRT, it_q[k].den);
        it_q[k+1].ln[1] <= lane_step(it_q[k].ln[1], it_q[k].mode == MODE_DIV,
                                     1'b0, it_q[k].den);
      end
    end
  end

  assign out_ch.valid  = out_vld_q;
  assign out_ch.res_re = res_re_q;
  assign out_ch.res_im = res_im_q;
  assign out_ch.status = status_q;

endmodule
